@@ rtl/core/rph_pkg.sv @@
// ----------------------------------------------------------------------------
// rph_pkg: shared types and constants of the rdm packet header checker
// packet form codes, start codes, the per-byte parse view and the verdict
// ----------------------------------------------------------------------------
package rph_pkg;

   localparam int unsigned HDR_LEN   = 24;
   localparam int unsigned POS_W     = 9;
   localparam int unsigned PRE_W     = 4;
   localparam int unsigned REQ_DW    = 8;
   localparam int unsigned RSP_DW    = 176;
   localparam int unsigned RSP_UW    = 2;

   localparam logic [7:0]       START_STD     = 8'hCC;
   localparam logic [7:0]       STD_SUB_START = 8'h01;
   localparam logic [7:0]       DISC_PREAMBLE = 8'hFE;
   localparam logic [7:0]       DISC_DELIM    = 8'hAA;
   localparam logic [7:0]       MIN_LENGTH    = 8'd3;
   localparam logic [POS_W-1:0] POS_MAX       = 9'd511;
   localparam logic [POS_W-1:0] DISC_UID_RAW  = 9'd12;
   localparam logic [POS_W-1:0] DISC_BODY     = 9'd16;
   localparam logic [POS_W-1:0] DISC_SUM_HI   = 9'd13;
   localparam logic [POS_W-1:0] DISC_SUM_LO   = 9'd15;
   localparam logic [7:0]       DISC_EXTRA    = 8'd17;
   localparam logic [47:0]      BCAST_UID     = 48'hFFFF_FFFF_FFFF;
   localparam logic [7:0]       DISC_CC       = 8'h11;
   localparam logic [15:0]      DISC_PID      = 16'h0001;

   typedef enum logic [1:0] {
      FORM_UNKNOWN,
      FORM_STANDARD,
      FORM_SEEK,
      FORM_BODY
   } form_type;

   // parse state as it stands after the current byte
   typedef struct packed {
      form_type                 form;
      logic                     failed;
      logic [POS_W-1:0]         count;
      logic [15:0]              run_sum;
      logic [15:0]              rcv_sum;
      logic [7:0]               length;
      logic [PRE_W-1:0]         preamble;
      logic [HDR_LEN-1:0][7:0]  hdr;
   } snap_type;

   typedef struct packed {
      logic        ok;
      logic        is_discovery;
      logic [7:0]  message_length;
      logic [47:0] dst_uid;
      logic [47:0] src_uid;
      logic [7:0]  transaction_number;
      logic [7:0]  port_or_response;
      logic [7:0]  msg_count;
      logic [15:0] subdev_num;
      logic [7:0]  command_class;
      logic [15:0] parameter_id;
      logic [7:0]  param_data_length;
   } verdict_type;

endpackage

@@ rtl/core/rph_parse.sv @@
// ----------------------------------------------------------------------------
// rph_parse: per-byte packet parser
// tracks form, position, sums and the header store; shows the post-byte view
// ----------------------------------------------------------------------------
module rph_parse #(
   parameter int unsigned MAX_PREAMBLE = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        rx_byte,
   input  logic              end_of_packet,
   output rph_pkg::snap_type snap
);
   import rph_pkg::*;

   form_type                form_ff, form_in;
   logic                    failed_ff, failed_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [15:0]             run_ff, run_in;
   logic [15:0]             rcv_ff, rcv_in;
   logic [7:0]              len_ff, len_in;
   logic [PRE_W-1:0]        pre_ff, pre_in;
   logic [7:0]              pair_ff, pair_in;
   logic [HDR_LEN-1:0][7:0] hdr_ff, hdr_in;

   always_comb begin
      logic             std_act;
      logic [POS_W-1:0] k;
      logic [7:0]       d;
      form_in   = form_ff;
      failed_in = failed_ff;
      run_in    = run_ff;
      rcv_in    = rcv_ff;
      len_in    = len_ff;
      pre_in    = pre_ff;
      pair_in   = pair_ff;
      hdr_in    = hdr_ff;
      std_act   = 1'b0;
      k         = pos_ff - POS_W'(pre_ff) - 9'd1;
      d         = pair_ff & rx_byte;
      if (!failed_ff) begin
         case (form_ff)
            FORM_UNKNOWN: begin
               if (rx_byte == START_STD) begin
                  form_in = FORM_STANDARD;
                  std_act = 1'b1;
               end else if (rx_byte == DISC_PREAMBLE) begin
                  form_in = FORM_SEEK;
               end else if (rx_byte == DISC_DELIM) begin
                  form_in = FORM_BODY;
                  pre_in  = '0;
               end else begin
                  failed_in = 1'b1;
               end
            end
            FORM_STANDARD: std_act = 1'b1;
            FORM_SEEK: begin
               if (rx_byte == DISC_DELIM) begin
                  pre_in  = pos_ff[PRE_W-1:0];
                  form_in = FORM_BODY;
               end else if (pos_ff >= POS_W'(MAX_PREAMBLE)) begin
                  failed_in = 1'b1;
               end
            end
            FORM_BODY: begin
               if (k < DISC_BODY) begin
                  if (!k[0]) begin
                     pair_in = rx_byte;
                  end else if (k < DISC_UID_RAW) begin
                     hdr_in[{2'b00, k[3:1]}] = d;
                  end else if (k == DISC_SUM_HI) begin
                     rcv_in = {d, 8'h00};
                  end else if (k == DISC_SUM_LO) begin
                     rcv_in = {rcv_ff[15:8], d};
                  end
                  if (k < DISC_UID_RAW) begin
                     run_in = run_ff + 16'(rx_byte);
                  end
               end
            end
            default: failed_in = 1'b1;
         endcase
      end
      if (std_act) begin
         if (pos_ff < POS_W'(HDR_LEN)) begin
            hdr_in[pos_ff[4:0]] = rx_byte;
         end
         if (pos_ff == 9'd1 && rx_byte != STD_SUB_START) begin
            failed_in = 1'b1;
         end
         if (pos_ff == 9'd2) begin
            len_in = rx_byte;
            if (rx_byte < MIN_LENGTH) begin
               failed_in = 1'b1;
            end
         end
         if (pos_ff <= 9'd2 || pos_ff < POS_W'(len_ff)) begin
            run_in = run_ff + 16'(rx_byte);
         end else if (pos_ff == POS_W'(len_ff)) begin
            rcv_in = {rx_byte, 8'h00};
         end else if (pos_ff == POS_W'(len_ff) + 9'd1) begin
            rcv_in = {rcv_ff[15:8], rx_byte};
         end
      end
      pos_in = (pos_ff < POS_MAX) ? pos_ff + 9'd1 : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         form_ff   <= FORM_UNKNOWN;
         failed_ff <= 1'b0;
         pos_ff    <= '0;
         run_ff    <= '0;
         rcv_ff    <= '0;
         len_ff    <= '0;
         pre_ff    <= '0;
         pair_ff   <= '0;
      end else if (step && end_of_packet) begin
         form_ff   <= FORM_UNKNOWN;
         failed_ff <= 1'b0;
         pos_ff    <= '0;
         run_ff    <= '0;
         rcv_ff    <= '0;
         len_ff    <= '0;
         pre_ff    <= '0;
         pair_ff   <= '0;
      end else if (step) begin
         form_ff   <= form_in;
         failed_ff <= failed_in;
         pos_ff    <= pos_in;
         run_ff    <= run_in;
         rcv_ff    <= rcv_in;
         len_ff    <= len_in;
         pre_ff    <= pre_in;
         pair_ff   <= pair_in;
      end
   end

   // header store: no reset, standard-form reads are masked by byte count
   always_ff @(posedge clock) begin
      if (step) begin
         hdr_ff <= hdr_in;
      end
   end

   always_comb begin
      snap.form     = form_in;
      snap.failed   = failed_in;
      snap.count    = pos_in;
      snap.run_sum  = run_in;
      snap.rcv_sum  = rcv_in;
      snap.length   = len_in;
      snap.preamble = pre_in;
      snap.hdr      = hdr_in;
   end

endmodule

@@ rtl/core/rph_verdict.sv @@
// ----------------------------------------------------------------------------
// rph_verdict: end-of-packet verdict and header field assembly
// checks lengths and checksum, masks header bytes that never arrived
// ----------------------------------------------------------------------------
module rph_verdict (
   input  rph_pkg::snap_type    snap,
   output rph_pkg::verdict_type verdict
);
   import rph_pkg::*;

   logic                    sum_match;
   logic                    ok_std;
   logic                    ok_disc;
   logic [HDR_LEN-1:0][7:0] h;

   assign sum_match = (snap.run_sum == snap.rcv_sum);
   assign ok_std  = !snap.failed && snap.form == FORM_STANDARD && snap.count >= 9'd3
                    && snap.count >= POS_W'(snap.length) + 9'd2 && sum_match;
   assign ok_disc = !snap.failed && snap.form == FORM_BODY
                    && snap.count >= POS_W'(snap.preamble) + POS_W'(DISC_EXTRA) && sum_match;

   always_comb begin
      for (int i = 0; i < HDR_LEN; i++) begin
         h[i] = (snap.count > POS_W'(i)) ? snap.hdr[i] : 8'h00;
      end
   end

   always_comb begin
      verdict              = '0;
      verdict.ok           = ok_std || ok_disc;
      verdict.is_discovery = snap.form[1];
      if (ok_std) begin
         verdict.message_length     = snap.length;
         verdict.dst_uid            = {h[3], h[4], h[5], h[6], h[7], h[8]};
         verdict.src_uid            = {h[9], h[10], h[11], h[12], h[13], h[14]};
         verdict.transaction_number = h[15];
         verdict.port_or_response   = h[16];
         verdict.msg_count          = h[17];
         verdict.subdev_num         = {h[18], h[19]};
         verdict.command_class      = h[20];
         verdict.parameter_id       = {h[21], h[22]};
         verdict.param_data_length  = h[23];
      end else if (ok_disc) begin
         verdict.message_length = 8'(snap.preamble) + DISC_EXTRA;
         verdict.dst_uid        = BCAST_UID;
         verdict.src_uid        = {snap.hdr[0], snap.hdr[1], snap.hdr[2],
                                   snap.hdr[3], snap.hdr[4], snap.hdr[5]};
         verdict.command_class  = DISC_CC;
         verdict.parameter_id   = DISC_PID;
      end
   end

endmodule

@@ rtl/core/rdm_packet_header_checker.sv @@
// ----------------------------------------------------------------------------
// rdm_packet_header_checker: rdm receive-side packet check and header decode
// one byte per transaction in, one verdict per packet out
// ----------------------------------------------------------------------------
// Received RDM bytes enter one per req transaction in wire order, req_tlast
// marking the last byte of a packet. On that byte one rsp transaction carries
// the verdict (ok) and the form (discovery or standard) in rsp_tuser and the
// decoded header in rsp_tdata; a failed packet gives an all-zero rsp_tdata.
// The block sustains one byte per clock: each byte is parsed by the position
// counter and 16-bit running sum between the input register and the result
// register, so a byte is taken every cycle; only a packet-end byte waits,
// while the result register holds a verdict that is not being drained. A
// req_tlast byte passes the input register and then the result register on
// its way to a verdict on rsp. Bytes past the checksum are left out of the
// sum check, and the parser returns to its start state after every packet end.
module rdm_packet_header_checker #(
   parameter int unsigned MAX_PREAMBLE = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   // rx_byte [7:0]
   input  logic [rph_pkg::REQ_DW-1:0]  req_tdata,
   input  logic                        req_tlast,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // message_length [7:0], dst_uid [55:8], src_uid [103:56],
   // transaction_number [111:104], port_or_response [119:112],
   // msg_count [127:120], subdev_num [143:128], command_class [151:144],
   // parameter_id [167:152], param_data_length [175:168]
   output logic [rph_pkg::RSP_DW-1:0]  rsp_tdata,
   // ok [0], is_discovery [1]
   output logic [rph_pkg::RSP_UW-1:0]  rsp_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready
);
   import rph_pkg::*;

   // input register
   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;
   logic        in_eop_ff;
   // result register
   logic        rsp_vld_ff;
   verdict_type rsp_ff;

   logic        advance;
   snap_type    snap;
   verdict_type verdict;

   // a packet-end byte needs a free (or draining) result register
   assign advance    = in_vld_ff && (!in_eop_ff || !rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[7:0];
         in_eop_ff  <= req_tlast;
      end
   end

   rph_parse #(
      .MAX_PREAMBLE (MAX_PREAMBLE)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .rx_byte       (in_byte_ff),
      .end_of_packet (in_eop_ff),
      .snap          (snap)
   );

   rph_verdict u_verdict (
      .snap    (snap),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && in_eop_ff) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_eop_ff) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = {rsp_ff.is_discovery, rsp_ff.ok};
   assign rsp_tdata  = {rsp_ff.param_data_length, rsp_ff.parameter_id,
                        rsp_ff.command_class, rsp_ff.subdev_num,
                        rsp_ff.msg_count, rsp_ff.port_or_response,
                        rsp_ff.transaction_number, rsp_ff.src_uid,
                        rsp_ff.dst_uid, rsp_ff.message_length};

   // a failed verdict carries no header
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("failed verdict with nonzero header");

   // a packet-end byte taken by the parser shows up as a verdict next cycle
   a_eop_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_eop_ff |=> rsp_tvalid)
      else $error("packet end without verdict");

   // a good discovery verdict is always broadcast-addressed
   a_disc_bcast: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && rsp_tuser[1] |-> rsp_tdata[55:8] == BCAST_UID)
      else $error("discovery verdict without broadcast destination");

endmodule

@@ tb/sv/rdm_header_verdict_check.sv @@
// ----------------------------------------------------------------------------
// rdm_header_verdict_check: verdict prediction and compare for the rdm checker
// follows every accepted byte, predicts the verdict of each packet end and
// compares it field by field with the rsp transactions in order
// ----------------------------------------------------------------------------
module rdm_header_verdict_check #(
   parameter int unsigned MAX_PREAMBLE = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rph_pkg::REQ_DW-1:0]  req_tdata,
   input  logic                        req_tlast,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [rph_pkg::RSP_DW-1:0]  rsp_tdata,
   input  logic [rph_pkg::RSP_UW-1:0]  rsp_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output int unsigned                 fail_count,
   output int unsigned                 pending
);

   import rph_pkg::*;

   localparam int REPORT_MAX = 40;

   // parse state of the packet in flight
   logic [POS_W-1:0] pos;
   form_type         form;
   logic [15:0]      run_sum;
   logic [15:0]      rcv_sum;
   logic [7:0]       len_byte;
   logic [7:0]       hdr_b [HDR_LEN];
   logic [PRE_W-1:0] pre_len;
   logic [7:0]       pair_b;
   logic             failed;

   verdict_type expected_verdicts [$];
   int          errs = 0;
   int          verdicts_seen = 0;

   task automatic clear_parse();
      pos = '0;
      form = FORM_UNKNOWN;
      run_sum = '0;
      rcv_sum = '0;
      len_byte = '0;
      pre_len = '0;
      pair_b = '0;
      failed = 1'b0;
      foreach (hdr_b[i]) hdr_b[i] = '0;
   endtask

   task automatic report_mismatch(input string msg);
      errs++;
      if (errs <= REPORT_MAX) $display("[%0t] verdict %0d: %s", $time, verdicts_seen, msg);
   endtask

   task automatic check_field(input string name, input logic [47:0] got,
                              input logic [47:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // standard form: header capture, length byte, running sum and checksum
   task automatic standard_byte(input int p, input logic [7:0] b);
      if (p < HDR_LEN) hdr_b[p] = b;
      if (p == 1 && b != STD_SUB_START) failed = 1'b1;
      if (p == 2) begin
         len_byte = b;
         if (b < MIN_LENGTH) failed = 1'b1;
      end
      if (p <= 2 || p < int'(len_byte)) begin
         run_sum = run_sum + 16'(b);
      end else if (p == int'(len_byte)) begin
         rcv_sum = {b, 8'h00};
      end else if (p == int'(len_byte) + 1) begin
         rcv_sum = rcv_sum | 16'(b);
      end
   endtask

   // discovery body: 12 encoded uid bytes then 4 encoded checksum bytes
   task automatic discovery_byte(input int p, input logic [7:0] b);
      int         k;
      logic [7:0] d;
      k = p - int'(pre_len) - 1;
      if (k < 16) begin
         if (k % 2 == 0) begin
            pair_b = b;
         end else begin
            d = pair_b & b;
            if (k < 12) begin
               hdr_b[k / 2] = d;
            end else if (k == 13) begin
               rcv_sum = {d, 8'h00};
            end else if (k == 15) begin
               rcv_sum = rcv_sum | 16'(d);
            end
         end
         if (k < 12) run_sum = run_sum + 16'(b);
      end
   endtask

   task automatic parse_rx_byte(input logic [7:0] b, input logic eop);
      int          p;
      int          n;
      logic        ok;
      verdict_type v;
      p = int'(pos);
      if (!failed) begin
         case (form)
            FORM_UNKNOWN: begin
               if (b == START_STD) begin
                  form = FORM_STANDARD;
                  standard_byte(p, b);
               end else if (b == DISC_PREAMBLE) begin
                  form = FORM_SEEK;
               end else if (b == DISC_DELIM) begin
                  form = FORM_BODY;
                  pre_len = '0;
               end else begin
                  failed = 1'b1;
               end
            end
            FORM_STANDARD: standard_byte(p, b);
            FORM_SEEK: begin
               if (b == DISC_DELIM) begin
                  pre_len = p[PRE_W-1:0];
                  form = FORM_BODY;
               end else if (p >= int'(MAX_PREAMBLE)) begin
                  failed = 1'b1;
               end
            end
            default: discovery_byte(p, b);
         endcase
      end
      // position saturates on very long packets
      if (pos < POS_MAX) pos = pos + 1'b1;
      if (eop) begin
         n = int'(pos);
         ok = 1'b0;
         if (!failed && form == FORM_STANDARD) begin
            ok = n >= 3 && n >= int'(len_byte) + 2 && run_sum == rcv_sum;
         end else if (!failed && form == FORM_BODY) begin
            ok = n >= int'(pre_len) + 17 && run_sum == rcv_sum;
         end
         v = '0;
         v.ok = ok;
         v.is_discovery = (form == FORM_SEEK || form == FORM_BODY);
         if (ok && form == FORM_STANDARD) begin
            // bytes not received are still zero from the clear
            v.message_length     = len_byte;
            v.dst_uid            = {hdr_b[3], hdr_b[4], hdr_b[5], hdr_b[6], hdr_b[7], hdr_b[8]};
            v.src_uid            = {hdr_b[9], hdr_b[10], hdr_b[11], hdr_b[12], hdr_b[13],
                                    hdr_b[14]};
            v.transaction_number = hdr_b[15];
            v.port_or_response   = hdr_b[16];
            v.msg_count          = hdr_b[17];
            v.subdev_num         = {hdr_b[18], hdr_b[19]};
            v.command_class      = hdr_b[20];
            v.parameter_id       = {hdr_b[21], hdr_b[22]};
            v.param_data_length  = hdr_b[23];
         end else if (ok) begin
            v.message_length = 8'(pre_len) + DISC_EXTRA;
            v.dst_uid        = BCAST_UID;
            v.src_uid        = {hdr_b[0], hdr_b[1], hdr_b[2], hdr_b[3], hdr_b[4], hdr_b[5]};
            v.command_class  = DISC_CC;
            v.parameter_id   = DISC_PID;
         end
         expected_verdicts.push_back(v);
         clear_parse();
      end
   endtask

   task automatic check_verdict();
      verdict_type want;
      if (expected_verdicts.size() == 0) begin
         report_mismatch("verdict with no packet end pending");
      end else begin
         want = expected_verdicts.pop_front();
         check_field("ok", rsp_tuser[0], want.ok);
         check_field("is_discovery", rsp_tuser[1], want.is_discovery);
         check_field("message_length", rsp_tdata[7:0], want.message_length);
         check_field("dst_uid", rsp_tdata[55:8], want.dst_uid);
         check_field("src_uid", rsp_tdata[103:56], want.src_uid);
         check_field("transaction_number", rsp_tdata[111:104], want.transaction_number);
         check_field("port_or_response", rsp_tdata[119:112], want.port_or_response);
         check_field("msg_count", rsp_tdata[127:120], want.msg_count);
         check_field("subdev_num", rsp_tdata[143:128], want.subdev_num);
         check_field("command_class", rsp_tdata[151:144], want.command_class);
         check_field("parameter_id", rsp_tdata[167:152], want.parameter_id);
         check_field("param_data_length", rsp_tdata[175:168], want.param_data_length);
      end
      verdicts_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         expected_verdicts.delete();
      end else begin
         // compare before predicting so a verdict never meets its own byte
         if (rsp_tvalid && rsp_tready) check_verdict();
         if (req_tvalid && req_tready) parse_rx_byte(req_tdata, req_tlast);
      end
      pending <= expected_verdicts.size();
      fail_count <= errs;
   end

endmodule

@@ tb/sv/rdm_packet_header_checker_tb.sv @@
// ----------------------------------------------------------------------------
// rdm_packet_header_checker_tb: top of the rdm packet header checker bench
// sends directed and random rdm packets byte by byte under varying idle and
// stall patterns; the verdict checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module rdm_packet_header_checker_tb;

   import rph_pkg::*;

   localparam int unsigned MAX_PREAMBLE = 7;
   localparam int unsigned RANDOM_BYTES = 860;
   localparam int unsigned PHASE_BYTES  = 215;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   // rx_byte [7:0]
   logic [REQ_DW-1:0] req_tdata = '0;
   logic              req_tlast = 1'b0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   // message_length [7:0], dst_uid [55:8], src_uid [103:56],
   // transaction_number [111:104], port_or_response [119:112],
   // msg_count [127:120], subdev_num [143:128], command_class [151:144],
   // parameter_id [167:152], param_data_length [175:168]
   logic [RSP_DW-1:0] rsp_tdata;
   // ok [0], is_discovery [1]
   logic [RSP_UW-1:0] rsp_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;

   int unsigned   fail_count;
   int unsigned   pending;
   idle_mode_type idle_mode = IDLE_NONE;
   int unsigned   quiet_cycles = 0;
   int unsigned   bytes_sent = 0;
   // bytes of the packet about to be sent, in wire order
   logic [7:0]    pkt [$];

   rdm_packet_header_checker #(
      .MAX_PREAMBLE(MAX_PREAMBLE)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   rdm_header_verdict_check #(
      .MAX_PREAMBLE(MAX_PREAMBLE)
   ) verdict_check (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver side: stall pattern follows the current idle mode
   always @(posedge clock) begin
      case (idle_mode)
         IDLE_RECEIVER: rsp_tready <= $urandom_range(99) >= 68;
         IDLE_BOTH:     rsp_tready <= $urandom_range(99) >= 38;
         default:       rsp_tready <= 1'b1;
      endcase
   end

   // watchdog: too long without any transaction on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("rdm_packet_header_checker_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] fill_byte(input fill_type f);
      case (f)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom);
      endcase
   endfunction

   // mostly full headers with small parameter data, some short and long ones
   function automatic int pick_length();
      int s;
      s = $urandom_range(99);
      if (s < 70) return $urandom_range(24, 40);
      if (s < 90) return $urandom_range(3, 23);
      if (s < 98) return $urandom_range(41, 120);
      return 255;
   endfunction

   // standard packet: start code, sub start, length, body, big-endian sum
   task automatic make_standard(input int len, input fill_type f);
      logic [15:0] sum;
      int          p;
      pkt.delete();
      pkt.push_back(START_STD);
      pkt.push_back(STD_SUB_START);
      pkt.push_back(8'(len));
      for (p = 3; p < len; p++) pkt.push_back(fill_byte(f));
      sum = '0;
      foreach (pkt[i]) sum = sum + 16'(pkt[i]);
      pkt.push_back(sum[15:8]);
      pkt.push_back(sum[7:0]);
   endtask

   // one decoded byte as two wire bytes whose and gives it back
   task automatic push_pair(input logic [7:0] v);
      logic [7:0] m;
      m = 8'($urandom);
      pkt.push_back(v | m);
      pkt.push_back(v | ~m);
   endtask

   // discovery response with the delimiter at position pre
   task automatic make_discovery(input int pre, input fill_type f);
      logic [15:0] sum;
      logic [7:0]  x;
      int          i;
      pkt.delete();
      if (pre == 0) begin
         pkt.push_back(DISC_DELIM);
      end else begin
         pkt.push_back(DISC_PREAMBLE);
         for (i = 1; i < pre; i++) begin
            // any byte but the delimiter may pad the preamble
            do x = 8'($urandom); while (x == DISC_DELIM);
            pkt.push_back($urandom_range(1) ? DISC_PREAMBLE : x);
         end
         pkt.push_back(DISC_DELIM);
      end
      sum = '0;
      for (i = 0; i < 6; i++) begin
         push_pair(fill_byte(f));
         sum = sum + 16'(pkt[pkt.size()-2]) + 16'(pkt[pkt.size()-1]);
      end
      push_pair(sum[15:8]);
      push_pair(sum[7:0]);
   endtask

   task automatic send_packet();
      int i;
      for (i = 0; i < pkt.size(); i++) begin
         while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 68) ||
                (idle_mode == IDLE_BOTH && $urandom_range(99) < 38)) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= pkt[i];
         req_tlast <= (i == pkt.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         bytes_sent++;
      end
   endtask

   initial begin
      int unsigned random_start;
      int          r;
      int          i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed packets
      make_standard(3, FILL_RANDOM);        // shortest valid, header bytes absent
      send_packet();
      make_standard(24, FILL_ONES);         // full header, all ones
      send_packet();
      make_standard(24, FILL_ZERO);         // full header, all zeros
      send_packet();
      make_standard(255, FILL_RANDOM);      // largest message length
      send_packet();
      make_standard(2, FILL_RANDOM);        // length too small to checksum
      send_packet();
      make_standard(0, FILL_RANDOM);
      send_packet();
      pkt.delete();                         // bad start code
      pkt.push_back(8'h00);
      send_packet();
      pkt.delete();
      pkt.push_back(8'hFF);
      pkt.push_back(8'h12);
      send_packet();
      make_standard(24, FILL_RANDOM);       // wrong sub start code
      pkt[1] = 8'h02;
      send_packet();
      pkt.delete();                         // start code alone
      pkt.push_back(START_STD);
      send_packet();
      pkt.delete();                         // preamble byte alone
      pkt.push_back(DISC_PREAMBLE);
      send_packet();
      make_discovery(0, FILL_ONES);         // delimiter first
      send_packet();
      make_discovery(MAX_PREAMBLE, FILL_ZERO); // longest preamble allowed
      send_packet();
      make_discovery(MAX_PREAMBLE + 1, FILL_RANDOM); // preamble too long
      send_packet();
      make_discovery(3, FILL_RANDOM);       // ends before last checksum byte
      void'(pkt.pop_back());
      send_packet();
      make_standard(30, FILL_RANDOM);
      void'(pkt.pop_back());
      send_packet();
      make_standard(26, FILL_RANDOM);       // trailing bytes after checksum
      repeat (3) pkt.push_back(8'($urandom));
      send_packet();
      make_discovery(2, FILL_RANDOM);
      repeat (2) pkt.push_back(8'($urandom));
      send_packet();
      make_standard(24, FILL_RANDOM);       // checksum off by one bit
      pkt[pkt.size()-1] = pkt[pkt.size()-1] ^ 8'h01;
      send_packet();
      make_discovery(1, FILL_RANDOM);       // raw uid byte changed, sum stale
      pkt[2] = pkt[2] ^ 8'h01;
      send_packet();
      make_standard(40, FILL_RANDOM);       // position counter saturates
      repeat (480) pkt.push_back(8'($urandom));
      send_packet();

      // random packets, idle mode rotating every few hundred bytes
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         idle_mode <= idle_mode_type'(((bytes_sent - random_start) / PHASE_BYTES) % 4);
         r = $urandom_range(99);
         if (r < 40) begin
            make_standard(pick_length(), FILL_RANDOM);
         end else if (r < 70) begin
            make_discovery($urandom_range(MAX_PREAMBLE), FILL_RANDOM);
         end else if (r < 80) begin
            // line noise, sometimes with a plausible start code
            pkt.delete();
            repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
            case ($urandom_range(3))
               0: pkt[0] = START_STD;
               1: pkt[0] = DISC_PREAMBLE;
               2: pkt[0] = DISC_DELIM;
               default: ;
            endcase
         end else begin
            // well-formed packet broken in one way
            if ($urandom_range(1)) make_standard(pick_length(), FILL_RANDOM);
            else make_discovery($urandom_range(MAX_PREAMBLE), FILL_RANDOM);
            case ($urandom_range(3))
               0: begin
                  i = $urandom_range(1, pkt.size() - 1);
                  while (pkt.size() > i) void'(pkt.pop_back());
               end
               1: make_discovery($urandom_range(MAX_PREAMBLE + 1, 12), FILL_RANDOM);
               2: make_standard($urandom_range(2), FILL_RANDOM);
               default: begin
                  i = $urandom_range(pkt.size() - 1);
                  pkt[i] = pkt[i] ^ 8'($urandom_range(1, 255));
               end
            endcase
         end
         if (r < 70 && $urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
         end
         send_packet();
      end

      // drain: receiver always ready, then wait out pending verdicts and anything stray
      idle_mode <= IDLE_NONE;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("rdm_packet_header_checker_tb passed");
      end else begin
         $display("rdm_packet_header_checker_tb failed");
      end
      $finish;
   end

endmodule
